### rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while dis is high
`define HKR_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("hkr assertion failed");

// next-cycle implication, disabled while dis is high
`define HKR_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("hkr assertion failed");

`endif

### rtl/hkr_pkg.sv
// shared constants and key code tables for the keyboard report decoder
`timescale 1ns / 1ps
`default_nettype none

package hkr_pkg;

  localparam int INPUT_SLOTS = 6;
  localparam int KEY_SLOTS_DEF = 6;
  localparam logic [7:0] MAX_USAGE = 8'd103;
  localparam logic [7:0] CODE_EMPTY = 8'd0;

  // usage code to character, plain or shifted layout; 0 means unmapped
  function automatic logic [7:0] map_char(input logic [7:0] code, input logic shifted);
    logic [7:0] c;
    begin
      c = 8'h00;
      if (code >= 8'd4 && code <= 8'd29) begin
        c = shifted ? (8'h41 + (code - 8'd4)) : (8'h61 + (code - 8'd4));
      end else if (code >= 8'd89 && code <= 8'd97) begin
        c = 8'h31 + (code - 8'd89);
      end else if (!shifted && code >= 8'd30 && code <= 8'd38) begin
        c = 8'h31 + (code - 8'd30);
      end else begin
        case (code)
          8'd39:  c = shifted ? 8'h29 : 8'h30;
          8'd30:  c = 8'h21;
          8'd31:  c = 8'h22;
          8'd32:  c = 8'hA3;
          8'd33:  c = 8'h24;
          8'd34:  c = 8'h25;
          8'd35:  c = 8'h5E;
          8'd36:  c = 8'h26;
          8'd37:  c = 8'h2A;
          8'd38:  c = 8'h28;
          8'd40:  c = 8'h0A;
          8'd42:  c = 8'h08;
          8'd43:  c = 8'h09;
          8'd44:  c = 8'h20;
          8'd45:  c = shifted ? 8'h5F : 8'h2D;
          8'd46:  c = shifted ? 8'h2B : 8'h3D;
          8'd47:  c = shifted ? 8'h7B : 8'h5B;
          8'd48:  c = shifted ? 8'h7D : 8'h5D;
          8'd49:  c = shifted ? 8'h7C : 8'h5C;
          8'd50:  c = shifted ? 8'h7E : 8'h23;
          8'd51:  c = shifted ? 8'h3A : 8'h3B;
          8'd52:  c = shifted ? 8'h40 : 8'h27;
          8'd53:  c = shifted ? 8'hAC : 8'h60;
          8'd54:  c = shifted ? 8'h3C : 8'h2C;
          8'd55:  c = shifted ? 8'h3E : 8'h2E;
          8'd56:  c = shifted ? 8'h3F : 8'h2F;
          8'd84:  c = 8'h2F;
          8'd85:  c = 8'h2A;
          8'd86:  c = 8'h2D;
          8'd87:  c = 8'h2B;
          8'd88:  c = 8'h0A;
          8'd98:  c = 8'h30;
          8'd99:  c = 8'h2E;
          8'd100: c = shifted ? 8'h7C : 8'h5C;
          8'd103: c = 8'h3D;
          default: c = 8'h00;
        endcase
      end
      return c;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/hkr_key_history.sv
// previous report's key slots and the per-slot repeat compare
`timescale 1ns / 1ps
`default_nettype none

module hkr_key_history #(
  parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 update,
  input  wire logic [7:0]           cur_slots [KEY_SLOTS],
  output logic      [KEY_SLOTS-1:0] seen_mask
);

  logic [7:0] prev_slots [KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) prev_slots[i] <= hkr_pkg::CODE_EMPTY;
    end else if (update) begin
      for (int i = 0; i < KEY_SLOTS; i++) prev_slots[i] <= cur_slots[i];
    end
  end

  // a slot is a repeat if its code sits anywhere in the previous report
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      seen_mask[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_slots[j] == cur_slots[i]) seen_mask[i] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/hkr_key_scan.sv
// ordered scan of the slots and character lookup
`timescale 1ns / 1ps
`default_nettype none

module hkr_key_scan #(
  parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
  input  wire logic [7:0]           cur_slots [KEY_SLOTS],
  input  wire logic [KEY_SLOTS-1:0] seen_mask,
  input  wire logic                 shifted,
  output logic      [7:0]           ascii_char
);

  logic       stopped;
  logic       found;
  logic [7:0] mapped;

  always_comb begin
    stopped = 1'b0;
    found = 1'b0;
    mapped = 8'h00;
    ascii_char = 8'h00;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      mapped = hkr_pkg::map_char(cur_slots[i], shifted);
      if (!stopped && !found) begin
        // an empty slot ends the scan
        if (cur_slots[i] == hkr_pkg::CODE_EMPTY) begin
          stopped = 1'b1;
        end else if (!seen_mask[i] && cur_slots[i] <= hkr_pkg::MAX_USAGE &&
                     mapped != 8'h00) begin
          ascii_char = mapped;
          found = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/hid_keyboard_report_to_ascii.sv
// Keyboard report to character converter, top level.
// Input channel: in_valid/in_ready carry one report (slot_0..slot_5 usage
// codes, left_shift, right_shift). Output channel: out_valid/out_ready
// carry one ascii_char per report, 0 when no new mapped key was pressed.
// Each report is compared against the previous report's slots, which are
// replaced by the current report when it is processed.
// A report passes through the input register, then the result register,
// which drives out_valid; a receiver stall can hold it in the input
// register. Throughput: one report per cycle while the receiver keeps up; the
// lookup is a single pass of compares and a table between the two registers.
// When the receiver stalls, the result register holds its value and the
// input register can still take one more report; in_ready drops only when
// both are full. Reset clears both valid flags and the stored slots to
// empty, so the first report sees no previous keys.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_report_to_ascii #(
  parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] slot_0,
  input  wire logic [7:0] slot_1,
  input  wire logic [7:0] slot_2,
  input  wire logic [7:0] slot_3,
  input  wire logic [7:0] slot_4,
  input  wire logic [7:0] slot_5,
  input  wire logic       left_shift,
  input  wire logic       right_shift,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] ascii_char
);

  logic                 stage_valid;
  logic [7:0]           stage_slots [hkr_pkg::INPUT_SLOTS];
  logic                 stage_shifted;
  logic                 advance;
  logic [7:0]           cur_slots [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] seen_mask;
  logic [7:0]           char_next;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) stage_valid <= in_valid;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_slots[0] <= slot_0;
      stage_slots[1] <= slot_1;
      stage_slots[2] <= slot_2;
      stage_slots[3] <= slot_3;
      stage_slots[4] <= slot_4;
      stage_slots[5] <= slot_5;
      stage_shifted  <= left_shift | right_shift;
    end
    if (advance) ascii_char <= char_next;
  end

  // slots past the report fields count as empty
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
    if (g < hkr_pkg::INPUT_SLOTS) begin : g_field
      assign cur_slots[g] = stage_slots[g];
    end else begin : g_empty
      assign cur_slots[g] = hkr_pkg::CODE_EMPTY;
    end
  end

  hkr_key_history #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .update    (advance),
    .cur_slots (cur_slots),
    .seen_mask (seen_mask)
  );

  hkr_key_scan #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_scan (
    .cur_slots  (cur_slots),
    .seen_mask  (seen_mask),
    .shifted    (stage_shifted),
    .ascii_char (char_next)
  );

endmodule

`default_nettype wire

### rtl/hkr_checker.sv
// port-level checks for the keyboard report decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hkr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] ascii_char
);

  // a stalled result holds its value
  `HKR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(ascii_char))

  // reset empties the result register
  `HKR_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // input back-pressure only when the result side is stalled
  `HKR_ASSERT_IMP(a_stall_cause, clk, rst, in_valid && !in_ready, out_valid && !out_ready)

  // characters are ASCII apart from the two Latin-1 signs
  `HKR_ASSERT_IMP(a_char_range, clk, rst, out_valid,
                  !ascii_char[7] || ascii_char == 8'hA3 || ascii_char == 8'hAC)

endmodule

bind hid_keyboard_report_to_ascii hkr_checker u_checker (.*);

`default_nettype wire

### bench/hkr_report_checker.sv
// checker for the keyboard report decoder: predicts each character and compares
`timescale 1ns / 1ps

module hkr_report_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] slot_0,
  input  logic [7:0] slot_1,
  input  logic [7:0] slot_2,
  input  logic [7:0] slot_3,
  input  logic [7:0] slot_4,
  input  logic [7:0] slot_5,
  input  logic       left_shift,
  input  logic       right_shift,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] ascii_char,
  output int         mismatch_count,
  output int         pending_chars
);

  logic [7:0] plain_glyph [0:255];
  logic [7:0] shifted_glyph [0:255];
  logic [7:0] expected_chars [$];
  logic [5:0][7:0] held_keys;
  logic [5:0][7:0] report_keys;
  logic [7:0] want_char;
  int results_seen;

  assign report_keys = {slot_5, slot_4, slot_3, slot_2, slot_1, slot_0};

  // key code tables, plain and shifted layout; 0 marks an unmapped code
  initial begin
    string dig_plain, dig_shifted, punct_plain, punct_shifted, keypad;
    int c;
    dig_plain = "1234567890";
    dig_shifted = "!\"#$%^&*()";
    punct_plain = " -=[]\\#;'`,./";
    punct_shifted = " _+{}|~:@?<>?";
    keypad = "/*-+\n1234567890.";
    for (c = 0; c < 256; c++) begin
      plain_glyph[c] = 8'h00;
      shifted_glyph[c] = 8'h00;
    end
    for (c = 0; c < 26; c++) begin
      plain_glyph[4 + c] = 8'(8'h61 + c);
      shifted_glyph[4 + c] = 8'(8'h41 + c);
    end
    for (c = 0; c < 10; c++) begin
      plain_glyph[30 + c] = dig_plain[c];
      shifted_glyph[30 + c] = dig_shifted[c];
    end
    for (c = 0; c < 13; c++) begin
      plain_glyph[44 + c] = punct_plain[c];
      shifted_glyph[44 + c] = punct_shifted[c];
    end
    for (c = 0; c < 16; c++) begin
      plain_glyph[84 + c] = keypad[c];
      shifted_glyph[84 + c] = keypad[c];
    end
    // latin-1 pound and not signs on the shifted layout
    shifted_glyph[32] = 8'hA3;
    shifted_glyph[53] = 8'hAC;
    plain_glyph[40] = 8'h0A;
    shifted_glyph[40] = 8'h0A;
    plain_glyph[42] = 8'h08;
    shifted_glyph[42] = 8'h08;
    plain_glyph[43] = 8'h09;
    shifted_glyph[43] = 8'h09;
    plain_glyph[100] = 8'h5C;
    shifted_glyph[100] = 8'h7C;
    plain_glyph[103] = 8'h3D;
    shifted_glyph[103] = 8'h3D;
  end

  // first key not held in the last report that maps to a character
  function automatic logic [7:0] first_new_char(input logic [5:0][7:0] keys,
                                                input logic [5:0][7:0] held,
                                                input logic shifted);
    logic [7:0] ch;
    logic [7:0] glyph;
    logic done;
    logic repeated;
    ch = 8'h00;
    done = 1'b0;
    for (int i = 0; i < hkr_pkg::INPUT_SLOTS; i++) begin
      if (!done) begin
        if (keys[i] == hkr_pkg::CODE_EMPTY) begin
          done = 1'b1;
        end else begin
          repeated = 1'b0;
          for (int j = 0; j < hkr_pkg::INPUT_SLOTS; j++) begin
            if (held[j] == keys[i]) repeated = 1'b1;
          end
          if (!repeated && keys[i] <= hkr_pkg::MAX_USAGE) begin
            glyph = shifted ? shifted_glyph[keys[i]] : plain_glyph[keys[i]];
            if (glyph != 8'h00) begin
              ch = glyph;
              done = 1'b1;
            end
          end
        end
      end
    end
    return ch;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_chars = 0;
    results_seen = 0;
    held_keys = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_chars.delete();
      held_keys = '0;
    end else begin
      // output side first: a report accepted now cannot produce its result yet
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result %0d: ascii_char %h with nothing pending",
                     results_seen, ascii_char);
          mismatch_count++;
        end else begin
          want_char = expected_chars.pop_front();
          if (want_char !== ascii_char) begin
            if (mismatch_count < 10)
              $display("result %0d: ascii_char expected %h actual %h",
                       results_seen, want_char, ascii_char);
            mismatch_count++;
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_chars.push_back(first_new_char(report_keys, held_keys,
                                                left_shift | right_shift));
        held_keys = report_keys;
      end
    end
    pending_chars = expected_chars.size();
  end

endmodule

### bench/hid_keyboard_report_to_ascii_test.sv
// top of the keyboard report decoder bench: clock, reset, report stimulus and verdict
`timescale 1ns / 1ps

module hid_keyboard_report_to_ascii_test;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_REPORTS = 300;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [5:0][7:0] drive_keys = '0;
  logic left_shift = 1'b0;
  logic right_shift = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] ascii_char;
  int mismatch_count;
  int pending_chars;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [5:0][7:0] last_keys = '0;

  hid_keyboard_report_to_ascii DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .slot_0(drive_keys[0]),
    .slot_1(drive_keys[1]),
    .slot_2(drive_keys[2]),
    .slot_3(drive_keys[3]),
    .slot_4(drive_keys[4]),
    .slot_5(drive_keys[5]),
    .left_shift(left_shift),
    .right_shift(right_shift),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ascii_char(ascii_char)
  );

  hkr_report_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .slot_0(drive_keys[0]),
    .slot_1(drive_keys[1]),
    .slot_2(drive_keys[2]),
    .slot_3(drive_keys[3]),
    .slot_4(drive_keys[4]),
    .slot_5(drive_keys[5]),
    .left_shift(left_shift),
    .right_shift(right_shift),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ascii_char(ascii_char),
    .mismatch_count(mismatch_count),
    .pending_chars(pending_chars)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ends the run when no transaction happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("hid_keyboard_report_to_ascii verification failed");
        $finish;
      end
    end
  end

  function automatic logic [5:0][7:0] keys6(input logic [7:0] k0, input logic [7:0] k1,
                                            input logic [7:0] k2, input logic [7:0] k3,
                                            input logic [7:0] k4, input logic [7:0] k5);
    return {k5, k4, k3, k2, k1, k0};
  endfunction

  task automatic send_report(input logic [5:0][7:0] keys, input logic ls, input logic rs);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    drive_keys <= keys;
    left_shift <= ls;
    right_shift <= rs;
    do @(posedge clk); while (!in_ready);
    last_keys = keys;
  endtask

  // sender goes quiet until every pending character has come out
  task automatic drain_chars;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars != 0) @(negedge clk);
  endtask

  task automatic send_random_report;
    logic [5:0][7:0] keys;
    int kind;
    int count;
    int pick;
    keys = '0;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // typing: packed keys, some still held from the last report
      count = $urandom_range(0, 6);
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25 && last_keys[i] != 8'h00)
          keys[i] = last_keys[i];
        else if (pick < 35)
          keys[i] = last_keys[3'($urandom_range(0, 5))];
        else if (pick < 80)
          keys[i] = 8'($urandom_range(4, 56));
        else if (pick < 92)
          keys[i] = 8'($urandom_range(57, 103));
        else
          keys[i] = 8'($urandom_range(0, 255));
      end
    end else if (kind < 85) begin
      for (int i = 0; i < 6; i++) keys[i] = 8'($urandom_range(0, 255));
    end else begin
      for (int i = 0; i < 6; i++)
        keys[i] = ($urandom_range(0, 99) < 30) ? 8'h00 : 8'($urandom_range(0, 255));
    end
    send_report(keys, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_report(keys6(0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
    send_report(keys6(4, 0, 0, 0, 0, 0), 1'b0, 1'b0);
    send_report(keys6(4, 0, 0, 0, 0, 0), 1'b0, 1'b0);     // held key gives nothing
    send_report(keys6(0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
    send_report(keys6(4, 5, 0, 0, 0, 0), 1'b1, 1'b0);
    send_report(keys6(5, 4, 6, 0, 0, 0), 1'b0, 1'b0);     // new key behind held ones
    send_report(keys6(0, 7, 0, 0, 0, 0), 1'b0, 1'b0);     // empty slot ends the scan
    send_report(keys6(1, 2, 3, 57, 225, 9), 1'b0, 1'b0);  // unmapped and high codes skipped
    send_report(keys6(104, 255, 103, 0, 0, 0), 1'b0, 1'b0);
    send_report(keys6(32, 0, 0, 0, 0, 0), 1'b0, 1'b1);
    send_report(keys6(53, 0, 0, 0, 0, 0), 1'b1, 1'b0);
    send_report(keys6(53, 0, 0, 0, 0, 0), 1'b1, 1'b1);
    send_report(keys6(0, 0, 0, 0, 0, 0), 1'b1, 1'b1);
    send_report(keys6(255, 255, 255, 255, 255, 255), 1'b1, 1'b1);
    send_report(keys6(128, 127, 101, 102, 41, 0), 1'b0, 1'b0);
    send_report(keys6(39, 0, 0, 0, 0, 0), 1'b1, 1'b0);
    send_report(keys6(100, 49, 0, 0, 0, 0), 1'b0, 1'b1);
    send_report(keys6(49, 100, 0, 0, 0, 0), 1'b0, 1'b0);
    send_report(keys6(84, 88, 98, 99, 0, 0), 1'b1, 1'b0);
    send_report(keys6(44, 40, 42, 43, 0, 0), 1'b0, 1'b0);
    send_report(keys6(30, 38, 0, 0, 0, 0), 1'b1, 1'b0);
    send_report(keys6(29, 56, 0, 0, 0, 0), 1'b0, 1'b0);
    drain_chars();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (PHASE_REPORTS) send_random_report();
      drain_chars();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_chars == 0)
      $display("hid_keyboard_report_to_ascii verification clean");
    else
      $display("hid_keyboard_report_to_ascii verification failed");
    $finish;
  end

endmodule
